// ===== design/flash_record_log_store_macros.svh =====
// Assertion macros shared by the checker of the flash record log store.
`ifndef FLASH_RECORD_LOG_STORE_MACROS_SVH
`define FLASH_RECORD_LOG_STORE_MACROS_SVH

// Property that holds at every clock edge outside reset.
`define FRLS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Antecedent in one cycle implies the consequent in the next.
`define FRLS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/frls_pkg.sv =====
// Shared types and constants of the flash record log store.
package frls_pkg;

  // Default geometry of the emulated flash array.
  localparam int SECTORS_DEF = 4;
  localparam int RPS_DEF     = 64;

  // Record layout, fixed by the width of the data ports.
  localparam int WORDS   = 4;
  localparam int WORD_W  = 32;
  localparam int WCNT_W  = $clog2(WORDS);
  localparam int ROW_W   = WORDS * WORD_W;

  typedef logic [WORDS-1:0][WORD_W-1:0] row_t;

  localparam logic [WORD_W-1:0] ERASED_WORD = '1;
  localparam row_t              ERASED_ROW  = '1;

  // Command codes.
  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_RESET = 2'd3
  } cmd_t;

  // Status codes.
  localparam int STATUS_W = 2;
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_DEFAULTS = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_GAVE_UP  = 2'd2;

  // Configuration register indexes and reset values.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THIRD  = 2'd2;

  localparam logic [WORD_W-1:0] DEF_FIRST_RST  = 32'd1;
  localparam logic [WORD_W-1:0] DEF_SECOND_RST = 32'd50;
  localparam logic [WORD_W-1:0] DEF_THIRD_RST  = 32'd50;

endpackage

// ===== design/flash_record_log_store.sv =====
// Flash record log store: wear-levelling settings log over an emulated flash array.
// A reset command is handled from idle; a read fetches the newest record; a start scans for the
// first blank record and fetches the one before it (the last one on a full store), or gives the
// defaults on an empty store; a write retries across records, up to NREC attempts.
// Throughput is one command at a time: busy stays high until the result word is strobed.
// Synchronous reset erases the array at once through per-record valid bits.
module flash_record_log_store #(
  parameter int SECTORS            = frls_pkg::SECTORS_DEF,
  parameter int RECORDS_PER_SECTOR = frls_pkg::RPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  frls_pkg::cmd_t                      cmd,
  input  logic [frls_pkg::WCNT_W-1:0]         word_index,
  input  logic [frls_pkg::WORD_W-1:0]         data_0,
  input  logic [frls_pkg::WORD_W-1:0]         data_1,
  input  logic [frls_pkg::WORD_W-1:0]         data_2,
  input  logic [frls_pkg::WORD_W-1:0]         data_3,
  input  logic                                cfg_write,
  input  logic [frls_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [frls_pkg::WORD_W-1:0]         cfg_data,
  output logic                                done,
  output logic [frls_pkg::STATUS_W-1:0]       status,
  output logic [frls_pkg::WORD_W-1:0]         read_word,
  output logic [frls_pkg::WORD_W-1:0]         setting_first,
  output logic [frls_pkg::WORD_W-1:0]         setting_second,
  output logic [frls_pkg::WORD_W-1:0]         setting_third
);
  import frls_pkg::*;

  localparam int NREC = SECTORS * RECORDS_PER_SECTOR;
  localparam int AW   = (NREC > 1) ? $clog2(NREC) : 1;
  localparam int FW   = $clog2(NREC + 2);
  localparam logic [AW-1:0] LAST = AW'(NREC - 1);
  localparam logic [FW-1:0] FAIL_LIMIT = FW'(NREC);
  localparam logic [WCNT_W-1:0] LAST_WORD = WCNT_W'(WORDS - 1);

  typedef enum logic [8:0] {
    ST_IDLE       = 9'b000000001,
    ST_SCAN_ADDR  = 9'b000000010,
    ST_SCAN_CHK   = 9'b000000100,
    ST_FETCH_ADDR = 9'b000001000,
    ST_FETCH_DATA = 9'b000010000,
    ST_W_ATT      = 9'b000100000,
    ST_W_LOAD     = 9'b001000000,
    ST_W_PROG     = 9'b010000000,
    ST_W_COMMIT   = 9'b100000000
  } state_t;

  state_t            state;
  logic [NREC-1:0]   valid;
  logic [AW-1:0]     next_record;
  logic              defaults_in_use;
  logic [FW-1:0]     failure_count;
  logic [WORD_W-1:0] def_first;
  logic [WORD_W-1:0] def_second;
  logic [WORD_W-1:0] def_third;

  logic [AW-1:0]     rec;
  logic [WCNT_W-1:0] wcnt;
  logic              prog_fail;
  row_t              cur_row;
  cmd_t              cmd_q;
  logic [WCNT_W-1:0] widx_q;
  row_t              data_q;

  logic [AW-1:0]     ram_raddr;
  logic [ROW_W-1:0]  ram_rdata;
  logic              ram_we;
  row_t              row_in;
  logic              blank;
  logic              rb_fail;
  logic [FW-1:0]     fc_sum;
  logic [AW-1:0]     newest;
  logic [AW-1:0]     next_inc;
  logic              done_next;

  assign busy = (state != ST_IDLE);

  // Record array; an entry whose valid bit is clear reads as erased.
  frls_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NREC)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (next_record),
    .wdata (ROW_W'(cur_row)),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Address selection, erased-row substitution and the shared compare and add.
  always_comb begin
    ram_raddr = (state == ST_W_ATT) ? next_record : rec;
    ram_we    = (state == ST_W_COMMIT);
    row_in    = valid[rec] ? row_t'(ram_rdata) : ERASED_ROW;
    blank     = !valid[rec] || (ram_rdata == ROW_W'(ERASED_ROW));
    rb_fail   = (cur_row[0] != data_q[0]);
    fc_sum    = failure_count + FW'(prog_fail) + FW'(rb_fail);
    newest    = (next_record == '0) ? LAST : next_record - 1'b1;
    next_inc  = (next_record == LAST) ? '0 : next_record + 1'b1;
  end

  // A command finishes in this cycle, so its result word is strobed in the next.
  always_comb begin
    done_next = ((state == ST_IDLE) && start && (cmd == CMD_RESET))
             || ((state == ST_SCAN_CHK) && blank && (rec == '0))
             || (state == ST_FETCH_DATA)
             || ((state == ST_W_COMMIT)
                 && ((fc_sum >= FAIL_LIMIT) || !(prog_fail || rb_fail)));
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      def_first  <= DEF_FIRST_RST;
      def_second <= DEF_SECOND_RST;
      def_third  <= DEF_THIRD_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_FIRST:  def_first  <= cfg_data;
        CFG_SECOND: def_second <= cfg_data;
        CFG_THIRD:  def_third  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Command sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      valid           <= '0;
      next_record     <= '0;
      defaults_in_use <= 1'b0;
      failure_count   <= '0;
      done            <= 1'b0;
    end else begin
      done <= done_next;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            cmd_q  <= cmd;
            widx_q <= word_index;
            data_q <= {data_3, data_2, data_1, data_0};
            unique case (cmd)
              CMD_START: begin
                rec   <= '0;
                state <= ST_SCAN_ADDR;
              end
              CMD_READ: begin
                rec   <= newest;
                state <= ST_FETCH_ADDR;
              end
              CMD_WRITE: begin
                state <= ST_W_ATT;
              end
              CMD_RESET: begin
                valid           <= '0;
                next_record     <= '0;
                defaults_in_use <= 1'b1;
                status          <= STATUS_DEFAULTS;
                read_word       <= '0;
                setting_first   <= def_first;
                setting_second  <= def_second;
                setting_third   <= def_third;
              end
              default: ;
            endcase
          end
        end

        ST_SCAN_ADDR: begin
          state <= ST_SCAN_CHK;
        end

        // Look for the first blank record, one record per pass through the address and check states.
        ST_SCAN_CHK: begin
          if (blank) begin
            if (rec == '0) begin
              next_record     <= '0;
              defaults_in_use <= 1'b1;
              status          <= STATUS_DEFAULTS;
              read_word       <= '0;
              setting_first   <= def_first;
              setting_second  <= def_second;
              setting_third   <= def_third;
              state           <= ST_IDLE;
            end else begin
              next_record <= rec;
              rec         <= rec - 1'b1;
              state       <= ST_FETCH_ADDR;
            end
          end else if (rec == LAST) begin
            next_record <= '0;
            state       <= ST_FETCH_ADDR;
          end else begin
            rec   <= rec + 1'b1;
            state <= ST_SCAN_ADDR;
          end
        end

        ST_FETCH_ADDR: begin
          state <= ST_FETCH_DATA;
        end

        // Deliver the settings or the requested word of the newest record.
        ST_FETCH_DATA: begin
          status <= STATUS_OK;
          if (cmd_q == CMD_START) begin
            read_word      <= '0;
            setting_first  <= row_in[0];
            setting_second <= row_in[1];
            setting_third  <= row_in[2];
          end else begin
            read_word      <= row_in[widx_q];
            setting_first  <= '0;
            setting_second <= '0;
            setting_third  <= '0;
          end
          state <= ST_IDLE;
        end

        // Start of a write attempt: erase on wrapping unless the defaults are in use.
        ST_W_ATT: begin
          if (next_record == '0) begin
            if (!defaults_in_use) begin
              valid <= '0;
            end else begin
              defaults_in_use <= 1'b0;
            end
          end
          rec       <= next_record;
          wcnt      <= '0;
          prog_fail <= 1'b0;
          state     <= ST_W_LOAD;
        end

        ST_W_LOAD: begin
          cur_row <= row_in;
          state   <= ST_W_PROG;
        end

        // Program one word per cycle; a word that is not erased ends the attempt.
        ST_W_PROG: begin
          if (cur_row[wcnt] == ERASED_WORD) begin
            cur_row[wcnt] <= data_q[wcnt];
            if (wcnt == LAST_WORD) begin
              state <= ST_W_COMMIT;
            end else begin
              wcnt <= wcnt + 1'b1;
            end
          end else begin
            prog_fail <= 1'b1;
            state     <= ST_W_COMMIT;
          end
        end

        // Write the record back, advance, and count failures.
        ST_W_COMMIT: begin
          valid[next_record] <= 1'b1;
          next_record        <= next_inc;
          if (fc_sum >= FAIL_LIMIT) begin
            failure_count  <= '0;
            status         <= STATUS_GAVE_UP;
            read_word      <= '0;
            setting_first  <= '0;
            setting_second <= '0;
            setting_third  <= '0;
            state          <= ST_IDLE;
          end else if (!(prog_fail || rb_fail)) begin
            failure_count  <= '0;
            status         <= STATUS_OK;
            read_word      <= '0;
            setting_first  <= '0;
            setting_second <= '0;
            setting_third  <= '0;
            state          <= ST_IDLE;
          end else begin
            failure_count <= fc_sum;
            state         <= ST_W_ATT;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/frls_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module frls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/frls_checker.sv =====
// Port-level checker of the flash record log store, bound to the top level.
`include "flash_record_log_store_macros.svh"

module frls_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input frls_pkg::cmd_t                cmd,
  input logic                          done,
  input logic [frls_pkg::STATUS_W-1:0] status
);
  import frls_pkg::*;

  logic accept;
  assign accept = start && !busy;

  // A result word is only shown once the sequencer has returned to idle.
  `FRLS_ASSERT(a_done_idle, done |-> !busy, "result word shown while busy")

  // Every result carries one of the defined status codes.
  `FRLS_ASSERT(a_status_code, done |-> (status == STATUS_OK || status == STATUS_DEFAULTS || status == STATUS_GAVE_UP), "undefined status code")

  // A reset command answers in the next cycle with the defaults status.
  `FRLS_ASSERT_NEXT(a_reset_cmd, accept && cmd == CMD_RESET, done && status == STATUS_DEFAULTS, "reset command gave no defaults result")

  // Any other command holds the block busy in the cycle after it is taken.
  `FRLS_ASSERT_NEXT(a_busy_after, accept && cmd != CMD_RESET, busy && !done, "block not busy after taking a command")

  // A read answers once the newest record has been fetched through the address and data states.
  `FRLS_ASSERT(a_read_latency, (accept && cmd == CMD_READ) |-> ##3 done, "read result late")

endmodule

bind flash_record_log_store frls_checker u_frls_checker (.*);

// ===== dv/flash_record_log_store_test.sv =====
// Self-checking testbench of the flash record log store: directed and random command words.
`timescale 1ns / 1ps

module flash_record_log_store_test;
  import frls_pkg::*;

  localparam int NREC = SECTORS_DEF * RPS_DEF;
  localparam int ITEM_TARGET = 950;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    word_t read_word;
    word_t first;
    word_t second;
    word_t third;
  } log_result_t;

  // Scoreboard: a private copy of the flash array and the log pointers, and the queue of
  // results still awaited from the block.
  class log_scoreboard;
    word_t flash [NREC][WORDS];
    int next_rec;
    bit defaults_in_use;
    int fail_count;
    word_t dflt [3];
    log_result_t awaited [$];
    int mismatches;

    function new();
      erase_flash();
      next_rec = 0;
      defaults_in_use = 1'b0;
      fail_count = 0;
      dflt[0] = DEF_FIRST_RST;
      dflt[1] = DEF_SECOND_RST;
      dflt[2] = DEF_THIRD_RST;
      mismatches = 0;
    endfunction

    function void erase_flash();
      foreach (flash[r, w]) flash[r][w] = ERASED_WORD;
    endfunction

    // The newest record sits just before the write pointer, wrapping to the last record.
    function int newest_rec();
      return (next_rec == 0) ? NREC - 1 : next_rec - 1;
    endfunction

    function void set_default(logic [CFG_IDX_W-1:0] idx, word_t val);
      if (idx == CFG_FIRST) dflt[0] = val;
      else if (idx == CFG_SECOND) dflt[1] = val;
      else if (idx == CFG_THIRD) dflt[2] = val;
    endfunction

    function int awaiting();
      return awaited.size();
    endfunction

    // Works out the result of one accepted command word and queues it.
    function void note_command(cmd_t c, logic [WCNT_W-1:0] wi, word_t d [WORDS]);
      log_result_t res;
      int first_blank;
      bit blank;
      bit failed;
      bit stop;
      bit finished;
      res.status = STATUS_OK;
      res.read_word = '0;
      res.first = '0;
      res.second = '0;
      res.third = '0;
      case (c)
        CMD_START: begin
          first_blank = -1;
          for (int r = 0; r < NREC && first_blank < 0; r++) begin
            blank = 1'b1;
            for (int w = 0; w < WORDS; w++)
              if (flash[r][w] != ERASED_WORD) blank = 1'b0;
            if (blank) first_blank = r;
          end
          if (first_blank == 0) begin
            next_rec = 0;
            res.first = dflt[0];
            res.second = dflt[1];
            res.third = dflt[2];
            defaults_in_use = 1'b1;
            res.status = STATUS_DEFAULTS;
          end else begin
            // A full store restarts the log at record 0.
            next_rec = (first_blank > 0) ? first_blank : 0;
            res.first = flash[newest_rec()][0];
            res.second = flash[newest_rec()][1];
            res.third = flash[newest_rec()][2];
          end
        end
        CMD_READ: begin
          res.read_word = flash[newest_rec()][wi];
        end
        CMD_WRITE: begin
          finished = 1'b0;
          while (!finished) begin
            failed = 1'b0;
            if (next_rec == 0) begin
              if (!defaults_in_use) erase_flash();
              else defaults_in_use = 1'b0;
            end
            // A word programs only when erased; the first refusal ends the attempt.
            stop = 1'b0;
            for (int w = 0; w < WORDS; w++) begin
              if (!stop) begin
                if (flash[next_rec][w] == ERASED_WORD) begin
                  flash[next_rec][w] = d[w];
                end else begin
                  fail_count++;
                  failed = 1'b1;
                  stop = 1'b1;
                end
              end
            end
            next_rec = (next_rec == NREC - 1) ? 0 : next_rec + 1;
            if (flash[newest_rec()][0] != d[0]) begin
              fail_count++;
              failed = 1'b1;
            end
            if (fail_count >= NREC) begin
              fail_count = 0;
              res.status = STATUS_GAVE_UP;
              finished = 1'b1;
            end else if (!failed) begin
              fail_count = 0;
              finished = 1'b1;
            end
          end
        end
        default: begin
          next_rec = 0;
          erase_flash();
          defaults_in_use = 1'b1;
          res.first = dflt[0];
          res.second = dflt[1];
          res.third = dflt[2];
          res.status = STATUS_DEFAULTS;
        end
      endcase
      awaited.push_back(res);
    endfunction

    // Compares one strobed result with the oldest awaited one.
    function void check_result(log_result_t got);
      log_result_t exp;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("error: result with nothing awaited (status %0d)", got.status);
        return;
      end
      exp = awaited.pop_front();
      if (got.status !== exp.status || got.read_word !== exp.read_word ||
          got.first !== exp.first || got.second !== exp.second || got.third !== exp.third) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: status %0d/%0d read %h/%h settings %h %h %h / %h %h %h",
                   exp.status, got.status, exp.read_word, got.read_word,
                   exp.first, exp.second, exp.third, got.first, got.second, got.third);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  cmd_t cmd = CMD_START;
  logic [WCNT_W-1:0] word_index = '0;
  word_t data_0 = '0;
  word_t data_1 = '0;
  word_t data_2 = '0;
  word_t data_3 = '0;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  word_t cfg_data = '0;
  logic done;
  logic [STATUS_W-1:0] status;
  word_t read_word;
  word_t setting_first;
  word_t setting_second;
  word_t setting_third;

  log_scoreboard sb = new();
  int sent = 0;
  bit no_idle = 1'b0;

  flash_record_log_store dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .word_index(word_index),
    .data_0(data_0),
    .data_1(data_1),
    .data_2(data_2),
    .data_3(data_3),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .done(done),
    .status(status),
    .read_word(read_word),
    .setting_first(setting_first),
    .setting_second(setting_second),
    .setting_third(setting_third)
  );

  always #5 clk = ~clk;

  // Result monitor: every strobed result is checked at the edge that ends its cycle.
  always @(posedge clk) begin : result_monitor
    log_result_t got;
    if (!rst && done) begin
      got.status = status;
      got.read_word = read_word;
      got.first = setting_first;
      got.second = setting_second;
      got.third = setting_third;
      sb.check_result(got);
    end
  end

  // Data words lean on the extremes now and then.
  function automatic word_t rand_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return ERASED_WORD;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 200);
  endfunction

  // Drives one command word from a falling edge until it is accepted, then idles at random.
  task automatic send_item(cmd_t c, logic [WCNT_W-1:0] wi, word_t d0, word_t d1,
                           word_t d2, word_t d3);
    word_t d [WORDS];
    int gap;
    d[0] = d0;
    d[1] = d1;
    d[2] = d2;
    d[3] = d3;
    cmd = c;
    word_index = wi;
    data_0 = d0;
    data_1 = d1;
    data_2 = d2;
    data_3 = d3;
    start = 1'b1;
    do @(posedge clk); while (busy);
    sb.note_command(c, wi, d);
    sent++;
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_cmd(cmd_t c);
    send_item(c, WCNT_W'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic send_write();
    send_item(CMD_WRITE, WCNT_W'($urandom_range(0, 3)), rand_word(), rand_word(),
              rand_word(), rand_word());
  endtask

  // Holds the sender off until every awaited result has come and the block is idle.
  task automatic drain();
    start = 1'b0;
    while (sb.awaiting() != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, word_t val);
    drain();
    cfg_index = idx;
    cfg_data = val;
    cfg_write = 1'b1;
    @(negedge clk);
    cfg_write = 1'b0;
    sb.set_default(idx, val);
  endtask

  // Random mix of commands inside one logging session.
  task automatic session_mix(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 60) send_write();
      else if (r < 80) send_cmd(CMD_READ);
      else if (r < 95) send_cmd(CMD_START);
      else send_cmd(CMD_RESET);
    end
  endtask

  // Timeout guard.
  initial begin
    #200_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part: empty store, extreme data, a blank-looking record, a retry.
    send_item(CMD_READ, 2'd3, '0, '0, '0, '0);
    send_cmd(CMD_START);
    send_item(CMD_WRITE, 2'd0, '0, '0, '0, '0);
    send_item(CMD_WRITE, 2'd1, ERASED_WORD, ERASED_WORD, ERASED_WORD, ERASED_WORD);
    send_item(CMD_WRITE, 2'd2, $urandom, $urandom, $urandom, $urandom);
    for (int i = 0; i < WORDS; i++)
      send_item(CMD_READ, i[WCNT_W-1:0], $urandom, $urandom, $urandom, $urandom);
    send_cmd(CMD_START);
    send_write();
    send_item(CMD_WRITE, 2'd0, $urandom, $urandom, $urandom, $urandom);
    send_cmd(CMD_RESET);
    send_item(CMD_WRITE, 2'd3, ERASED_WORD, $urandom, $urandom, $urandom);
    send_item(CMD_READ, 2'd0, $urandom, $urandom, $urandom, $urandom);
    write_cfg(CFG_FIRST, '0);
    write_cfg(CFG_SECOND, ERASED_WORD);
    write_cfg(CFG_THIRD, $urandom);
    write_cfg(CFG_UNUSED, $urandom);
    send_cmd(CMD_START);
    send_cmd(CMD_RESET);
    send_cmd(CMD_START);
    write_cfg(CFG_FIRST, ERASED_WORD);
    write_cfg(CFG_SECOND, '0);
    write_cfg(CFG_THIRD, '0);
    send_cmd(CMD_RESET);

    // Deep part: leave record 0 blank, fill the rest, then force retries until the
    // write gives up, start on a full store, and wrap with an erase.
    send_cmd(CMD_RESET);
    send_item(CMD_WRITE, 2'd0, ERASED_WORD, ERASED_WORD, ERASED_WORD, ERASED_WORD);
    for (int i = 1; i < NREC; i++)
      send_item(CMD_WRITE, 2'd0, $urandom, $urandom, $urandom, $urandom);
    send_cmd(CMD_START);
    send_item(CMD_WRITE, 2'd1, $urandom, $urandom, $urandom, $urandom);
    send_item(CMD_WRITE, 2'd2, $urandom, $urandom, $urandom, $urandom);
    send_cmd(CMD_START);
    send_cmd(CMD_READ);
    send_write();
    send_cmd(CMD_READ);

    // Random part: sessions of well-formed traffic, some noise, occasional settings changes.
    while (sent < ITEM_TARGET) begin
      no_idle = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1: begin
          for (int i = $urandom_range(5, 15); i > 0; i--)
            send_item(cmd_t'($urandom_range(0, 3)), WCNT_W'($urandom_range(0, 3)),
                      rand_word(), rand_word(), rand_word(), rand_word());
        end
        2, 3, 4, 5: begin
          if ($urandom_range(0, 1)) send_cmd(CMD_RESET);
          else send_cmd(CMD_START);
          session_mix($urandom_range(3, 20));
        end
        6, 7: begin
          // A blank record in the middle of the log makes later writes retry.
          send_cmd(CMD_START);
          for (int i = $urandom_range(2, 6); i > 0; i--) send_write();
          send_item(CMD_WRITE, WCNT_W'($urandom_range(0, 3)), ERASED_WORD, ERASED_WORD,
                    ERASED_WORD, ERASED_WORD);
          for (int i = $urandom_range(1, 5); i > 0; i--) send_write();
          send_cmd(CMD_START);
          session_mix($urandom_range(2, 8));
        end
        default: begin
          write_cfg(CFG_IDX_W'($urandom_range(0, 3)), rand_word());
          if ($urandom_range(0, 1)) send_cmd(CMD_RESET);
          else send_cmd(CMD_START);
          session_mix($urandom_range(1, 6));
        end
      endcase
    end

    drain();
    repeat (20) @(negedge clk);
    if (sb.mismatches == 0 && sb.awaiting() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
